[hw/rtl/xbaf_pkg.sv]
package xbaf_pkg;

	// configuration register file
	localparam int CFG_W  = 25;          // block_length register width
	localparam int REG_AW = 1;           // register index bits (byte address 4*i)
	localparam int APB_AW = REG_AW + 2;
	localparam int APB_DW = 32;
	localparam logic [REG_AW-1:0] REG_BLOCK_LENGTH = 1'b0;

	// opcode patterns
	localparam logic [7:0] OPC_PREFIX  = 8'h0F;
	localparam logic [7:0] OPC_CALL    = 8'hE8;
	localparam logic [7:0] MASK_CALL   = 8'hFE;
	localparam logic [7:0] MASK_HI     = 8'hF0;
	localparam logic [7:0] OPC_JCC_HI  = 8'h80;

	// operand arithmetic: 32-bit operand plus/minus a block offset, with sign
	localparam int OPND_W = 32;
	localparam int CV_W   = 34;

	// run queue between front and back
	localparam int QDEPTH = 8;
	localparam int QA_W   = 3;
	localparam int RUN_MAX = 4;
	localparam int CNT_W  = 3;

	// one run: the result bytes caused by one input byte, byte k at [8k+7:8k]
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [OPND_W-1:0] data;
	} run_t;

endpackage

[hw/rtl/x86_branch_address_filter_core.sv]
// Channel   Direction  Handshake                  Payload
// input     in         push / full                in_byte
// result    out        pop / empty                out_byte, last_of_run
// config    in/out     psel penable pwrite pready paddr, pwdata, prdata (block_length)
//
// One input byte per cycle while full is low; results leave at one per cycle while pop is held.
// A byte becomes a run of 0, 1, 2 or 4 result bytes in the front in the transfer cycle;
// the run passes through the run queue and the back's output register before it is visible.
// An eight-entry run queue decouples front and back: full rises only when
// eight runs wait, so input stalls come from result-side stalls alone.
// Reset is asynchronous: queue and output empty, scan phase and position zero,
// block_length = MAX_BLOCK.
module x86_branch_address_filter_core import xbaf_pkg::*; #(
	parameter int MAX_BLOCK = 16777216
) (
	input  logic              clk,
	input  logic              arst_n,
	// byte input
	input  logic              push,
	output logic              full,
	input  logic [7:0]        in_byte,
	// result output
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              last_of_run,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [CFG_W-1:0]  block_length_q;
	logic [REG_AW-1:0] reg_idx;
	logic              cfg_wr;
	logic              accept;
	logic              run_valid;
	run_t              run;
	logic              q_full, q_empty, q_pop;
	run_t              q_data;

	// config: register i at byte address 4*i, zero wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_BLOCK_LENGTH);

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_BLOCK_LENGTH) begin
			prdata = {{(APB_DW-CFG_W){1'b0}}, block_length_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= CFG_W'(MAX_BLOCK);
		end else if (cfg_wr) begin
			block_length_q <= pwdata[CFG_W-1:0];
		end
	end

	// input transfer; the front always has room for one run when the queue is not full
	assign full   = q_full;
	assign accept = push && !q_full;

	xbaf_front #(
		.MAX_BLOCK(MAX_BLOCK)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.block_length(block_length_q),
		.run_valid   (run_valid),
		.run         (run)
	);

	xbaf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (run_valid),
		.wr_data(run),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	// back: serializes each run, one byte per result transfer
	xbaf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.empty      (empty),
		.pop        (pop)
	);

	// a run is one plain byte, a released prefix pair, or a rewritten operand
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> (run.cnt == CNT_W'(1) || run.cnt == CNT_W'(2) ||
			run.cnt == CNT_W'(RUN_MAX)))
		else $error("front produced a run of illegal length");

	// bytes of one run are never split by a bubble
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_of_run) |=> !empty)
		else $error("result run interrupted");

	// queue full with nothing waiting is a pointer slip
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("run queue both full and empty");

	// a waiting run is taken by the back as soon as it is idle
	a_back_load: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !q_empty) |=> !empty)
		else $error("back idle while runs wait");

endmodule

[hw/rtl/xbaf_front.sv]
module xbaf_front import xbaf_pkg::*; #(
	parameter int MAX_BLOCK = 16777216
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic [CFG_W-1:0] block_length,
	output logic             run_valid,
	output run_t             run
);

	localparam int LEN_W = $clog2(MAX_BLOCK + 1);
	localparam int POS_W = $clog2(MAX_BLOCK);
	localparam int SUM_W = LEN_W + 1;

	typedef enum logic [2:0] {
		PH_SCAN,
		PH_PFX,
		PH_OP0,
		PH_OP1,
		PH_OP2,
		PH_OP3
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  ostart_q;
	logic [23:0]       opnd_q, opnd_d;

	logic [LEN_W-1:0]  len;
	logic [SUM_W-1:0]  pos_p5, pos_p1;
	logic              scan_ok, is_pfx, is_br, is_jcc, wrap, start_op;
	logic [OPND_W-1:0] raw, conv;
	logic [CV_W-1:0]   op_x, p_x, n_x, s_x, d_x;
	logic              in_lo, in_hi;

	// effective length, clamped to 1..MAX_BLOCK
	always_comb begin
		if (block_length == '0) begin
			len = LEN_W'(1);
		end else if (block_length > CFG_W'(MAX_BLOCK)) begin
			len = LEN_W'(MAX_BLOCK);
		end else begin
			len = block_length[LEN_W-1:0];
		end
	end

	assign pos_p5  = SUM_W'(pos_q) + SUM_W'(5);
	assign pos_p1  = SUM_W'(pos_q) + SUM_W'(1);
	assign scan_ok = pos_p5 < SUM_W'(len);
	assign wrap    = pos_p1 >= SUM_W'(len);
	assign is_pfx  = scan_ok && (in_byte == OPC_PREFIX);
	assign is_br   = scan_ok && ((in_byte & MASK_CALL) == OPC_CALL);
	assign is_jcc  = (in_byte & MASK_HI) == OPC_JCC_HI;

	// operand rewrite: s = op+p, d = op-len
	assign raw   = {in_byte, opnd_q};
	assign op_x  = {{(CV_W-OPND_W){raw[OPND_W-1]}}, raw};
	assign p_x   = {{(CV_W-LEN_W){1'b0}}, ostart_q};
	assign n_x   = {{(CV_W-LEN_W){1'b0}}, len};
	assign s_x   = op_x + p_x;
	assign d_x   = op_x - n_x;
	assign in_lo = !s_x[CV_W-1] && (s_x < n_x);
	assign in_hi = !s_x[CV_W-1] && !(s_x < n_x) && d_x[CV_W-1];
	assign conv  = in_lo ? s_x[OPND_W-1:0] : (in_hi ? d_x[OPND_W-1:0] : raw);

	always_comb begin
		phase_d  = phase_q;
		opnd_d   = opnd_q;
		start_op = 1'b0;
		run.cnt  = '0;
		run.data = '0;
		unique case (phase_q)
			PH_PFX: begin
				run.data[7:0] = OPC_PREFIX;
				if (is_jcc) begin
					run.data[15:8] = in_byte;
					run.cnt        = CNT_W'(2);
					start_op       = 1'b1;
					phase_d        = PH_OP0;
				end else if (is_pfx) begin
					run.cnt = CNT_W'(1);
					phase_d = PH_PFX;
				end else begin
					run.data[15:8] = in_byte;
					run.cnt        = CNT_W'(2);
					start_op       = is_br;
					phase_d        = is_br ? PH_OP0 : PH_SCAN;
				end
			end
			PH_OP0: begin
				opnd_d[7:0] = in_byte;
				phase_d     = PH_OP1;
			end
			PH_OP1: begin
				opnd_d[15:8] = in_byte;
				phase_d      = PH_OP2;
			end
			PH_OP2: begin
				opnd_d[23:16] = in_byte;
				phase_d       = PH_OP3;
			end
			PH_OP3: begin
				run.data = conv;
				run.cnt  = CNT_W'(RUN_MAX);
				phase_d  = PH_SCAN;
			end
			default: begin
				if (is_pfx) begin
					phase_d = PH_PFX;
				end else begin
					run.data[7:0] = in_byte;
					run.cnt       = CNT_W'(1);
					start_op      = is_br;
					phase_d       = is_br ? PH_OP0 : PH_SCAN;
				end
			end
		endcase
	end

	assign run_valid = accept && (run.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCAN;
			pos_q    <= '0;
			ostart_q <= '0;
			opnd_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			opnd_q  <= opnd_d;
			pos_q   <= wrap ? '0 : pos_p1[POS_W-1:0];
			if (start_op) begin
				ostart_q <= pos_p1[LEN_W-1:0];
			end
		end
	end

endmodule

[hw/rtl/xbaf_queue.sv]
module xbaf_queue import xbaf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  run_t wr_data,
	output logic full,
	input  logic rd_en,
	output run_t rd_data,
	output logic empty
);

	run_t            mem_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]   cnt_q;

	assign full    = cnt_q == (QA_W+1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QA_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QA_W+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/xbaf_back.sv]
module xbaf_back import xbaf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  run_t       q_data,
	output logic       q_pop,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       empty,
	input  logic       pop
);

	logic [OPND_W-1:0] data_q;
	logic [CNT_W-1:0]  rem_q;
	logic              take;

	assign take        = pop && (rem_q != '0);
	// load the next run when the current one is gone or leaves this cycle
	assign q_pop       = !q_empty && ((rem_q == '0) || (take && rem_q == CNT_W'(1)));
	assign out_byte    = data_q[7:0];
	assign last_of_run = rem_q == CNT_W'(1);
	assign empty       = rem_q == '0;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data.data;
		end else if (take) begin
			data_q <= data_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (q_pop) begin
			rem_q <= q_data.cnt;
		end else if (take) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

endmodule
